FILE: hw/rtl/mcfe_pkg.sv
// ----------------------------------------------------------------------------
// mcfe_pkg
// Shared types, constants and the crc helper for the motor command frame
// encoder.
// ----------------------------------------------------------------------------
package mcfe_pkg;

  localparam int WordW      = 16;
  localparam int ByteW      = 8;
  localparam int KindW      = 3;
  localparam int CfgIndexW  = 3;
  localparam int FrameLen   = 10;
  localparam int FrameIdxW  = $clog2(FrameLen);
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [WordW-1:0] CrcInit = 16'hFFFF;
  localparam logic [WordW-1:0] CrcPoly = 16'hA001;
  localparam logic [WordW-1:0] FreqMin = 16'd500;
  localparam logic [WordW-1:0] FreqMax = 16'd5000;

  typedef enum logic [KindW-1:0] {
    KindStop    = 3'd0,
    KindForward = 3'd1,
    KindReverse = 3'd2,
    KindFreq    = 3'd3,
    KindAccel   = 3'd4,
    KindDecel   = 3'd5
  } kind_t;

  typedef enum logic [CfgIndexW-1:0] {
    RegSync      = 3'd0,
    RegMotionAdr = 3'd1,
    RegStopCode  = 3'd2,
    RegFwdCode   = 3'd3,
    RegRevCode   = 3'd4,
    RegFreqAdr   = 3'd5,
    RegAccelAdr  = 3'd6,
    RegDecelAdr  = 3'd7
  } cfg_reg_t;

  // one resolved register write, as queued between front and back
  typedef struct packed {
    logic [WordW-1:0] addr;
    logic [WordW-1:0] word;
  } frame_req_t;

  // crc-16/modbus over one byte, lsb first
  function automatic logic [WordW-1:0] crc16_byte(input logic [WordW-1:0] crc_in,
                                                  input logic [ByteW-1:0] data);
    logic [WordW-1:0] c;
    c = crc_in ^ {{(WordW-ByteW){1'b0}}, data};
    for (int k = 0; k < ByteW; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/motor_command_frame_encoder_top.sv
// ----------------------------------------------------------------------------
// motor_command_frame_encoder_top
// Turns motor commands into ten-byte register write frames with crc.
// ----------------------------------------------------------------------------
// Each accepted command of kind 0..5 comes out as ten bytes, one per cycle
// while out_ready stays high; the byte rate is set by the back-end byte
// sequencer, which emits one frame position per cycle and folds each header
// byte into the crc as it goes. The front end resolves a command in the cycle
// it is accepted and parks it in a two-entry queue, so in_ready stays high
// while the queue has room; once the back end is free, the first byte of a
// queued frame is registered into the output register. Kinds 6 and 7 are
// accepted and dropped. Write the configuration registers only while no
// frame is pending.
module motor_command_frame_encoder_top import mcfe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [WordW-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KindW-1:0]     kind,
  input  logic [WordW-1:0]     value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ByteW-1:0]     frame_byte,
  output logic                 last_byte
);

  logic             q_full;
  logic             q_push;
  frame_req_t       q_data;
  logic             q_pop;
  logic             q_not_empty;
  frame_req_t       q_head;
  logic [WordW-1:0] sync_word;

  mcfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .value     (value),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data),
    .sync_word (sync_word)
  );

  mcfe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  mcfe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .sync_word   (sync_word),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_byte  (frame_byte),
    .last_byte   (last_byte)
  );

endmodule

FILE: hw/rtl/mcfe_front.sv
// ----------------------------------------------------------------------------
// mcfe_front
// Holds the configuration registers, accepts commands and resolves each one
// into a register address and value word for the queue.
// ----------------------------------------------------------------------------
module mcfe_front import mcfe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [WordW-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KindW-1:0]     kind,
  input  logic [WordW-1:0]     value,
  input  logic                 q_full,
  output logic                 q_push,
  output frame_req_t           q_data,
  output logic [WordW-1:0]     sync_word
);

  logic [WordW-1:0] motion_address;
  logic [WordW-1:0] stop_code;
  logic [WordW-1:0] forward_code;
  logic [WordW-1:0] reverse_code;
  logic [WordW-1:0] frequency_address;
  logic [WordW-1:0] acceleration_address;
  logic [WordW-1:0] deceleration_address;
  logic             kind_ok;
  logic [WordW-1:0] freq_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word            <= '0;
      motion_address       <= '0;
      stop_code            <= '0;
      forward_code         <= '0;
      reverse_code         <= '0;
      frequency_address    <= '0;
      acceleration_address <= '0;
      deceleration_address <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        RegSync:      sync_word            <= cfg_data;
        RegMotionAdr: motion_address       <= cfg_data;
        RegStopCode:  stop_code            <= cfg_data;
        RegFwdCode:   forward_code         <= cfg_data;
        RegRevCode:   reverse_code         <= cfg_data;
        RegFreqAdr:   frequency_address    <= cfg_data;
        RegAccelAdr:  acceleration_address <= cfg_data;
        RegDecelAdr:  deceleration_address <= cfg_data;
        default: ;
      endcase
    end
  end

  assign freq_word = (value < FreqMin) ? FreqMin :
                     (value > FreqMax) ? FreqMax : value;

  always_comb begin
    kind_ok     = 1'b1;
    q_data.addr = motion_address;
    q_data.word = stop_code;
    case (kind_t'(kind))
      KindStop: begin
        q_data.addr = motion_address;
        q_data.word = stop_code;
      end
      KindForward: begin
        q_data.addr = motion_address;
        q_data.word = forward_code;
      end
      KindReverse: begin
        q_data.addr = motion_address;
        q_data.word = reverse_code;
      end
      KindFreq: begin
        q_data.addr = frequency_address;
        q_data.word = freq_word;
      end
      KindAccel: begin
        q_data.addr = acceleration_address;
        q_data.word = value;
      end
      KindDecel: begin
        q_data.addr = deceleration_address;
        q_data.word = value;
      end
      default: kind_ok = 1'b0;
    endcase
  end

  // undefined kinds are consumed without producing a frame
  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready && kind_ok;

endmodule

FILE: hw/rtl/mcfe_queue.sv
// ----------------------------------------------------------------------------
// mcfe_queue
// Short show-ahead queue of resolved frame requests between front and back.
// ----------------------------------------------------------------------------
module mcfe_queue import mcfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  frame_req_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output frame_req_t head
);

  frame_req_t           entries [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueueCntW-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign full      = (count == QueueCntW'(QueueDepth));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/mcfe_back.sv
// ----------------------------------------------------------------------------
// mcfe_back
// Byte sequencer: walks the ten frame positions of the queue head into the
// output register, one byte per unstalled cycle, folding the header into crc.
// ----------------------------------------------------------------------------
module mcfe_back import mcfe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [WordW-1:0] sync_word,
  input  logic             q_not_empty,
  input  frame_req_t       q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ByteW-1:0] frame_byte,
  output logic             last_byte
);

  localparam logic [FrameIdxW-1:0] PosSyncHi = 4'd0;
  localparam logic [FrameIdxW-1:0] PosSyncLo = 4'd1;
  localparam logic [FrameIdxW-1:0] PosAddrHi = 4'd2;
  localparam logic [FrameIdxW-1:0] PosAddrLo = 4'd3;
  localparam logic [FrameIdxW-1:0] PosWordHi = 4'd4;
  localparam logic [FrameIdxW-1:0] PosWordLo = 4'd5;
  localparam logic [FrameIdxW-1:0] PosCrcLo  = 4'd6;
  localparam logic [FrameIdxW-1:0] PosCrcHi  = 4'd7;
  localparam logic [FrameIdxW-1:0] PosLast   = FrameIdxW'(FrameLen - 1);

  logic [FrameIdxW-1:0] pos;
  logic [WordW-1:0]     crc;
  logic [ByteW-1:0]     byte_next;
  logic                 load;
  logic                 in_header;

  assign load      = q_not_empty && (!out_valid || out_ready);
  assign q_pop     = load && (pos == PosLast);
  assign in_header = (pos <= PosWordLo);

  always_comb begin
    case (pos)
      PosSyncHi: byte_next = sync_word[15:8];
      PosSyncLo: byte_next = sync_word[7:0];
      PosAddrHi: byte_next = q_head.addr[15:8];
      PosAddrLo: byte_next = q_head.addr[7:0];
      PosWordHi: byte_next = q_head.word[15:8];
      PosWordLo: byte_next = q_head.word[7:0];
      PosCrcLo:  byte_next = crc[7:0];
      PosCrcHi:  byte_next = crc[15:8];
      default:   byte_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_byte <= byte_next;
      last_byte  <= (pos == PosLast);
      if (in_header) begin
        crc <= crc16_byte((pos == PosSyncHi) ? CrcInit : crc, byte_next);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        pos       <= (pos == PosLast) ? '0 : pos + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/mcfe_checker.sv
// ----------------------------------------------------------------------------
// mcfe_checker
// Port-level checks on the frame encoder output, bound to the top level.
// ----------------------------------------------------------------------------
module mcfe_checker import mcfe_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [ByteW-1:0]     frame_byte,
  input logic                 last_byte
);

  logic [FrameIdxW-1:0] byte_cnt;

  // position of the next output byte within its frame
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_cnt <= '0;
    end else if (out_valid && out_ready) begin
      byte_cnt <= (byte_cnt == FrameIdxW'(FrameLen - 1)) ? '0 : byte_cnt + 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(last_byte))
    else $error("output transaction changed while stalled");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_byte == (byte_cnt == FrameIdxW'(FrameLen - 1))))
    else $error("last_byte not on tenth byte of frame");

  a_tail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (byte_cnt >= FrameIdxW'(FrameLen - 2)) |-> frame_byte == '0)
    else $error("frame tail byte not zero");

  a_no_out_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind motor_command_frame_encoder_top mcfe_checker u_mcfe_checker (.*);
